[rtl/core/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
// No dependencies; each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/pbd_pkg.sv]
// Shared types and constants of the PackBits scanline decoder.
// No dependencies; imported by every decoder module.
package pbd_pkg;

  localparam logic [7:0]  SKIP_CODE        = 8'h80;
  localparam logic [15:0] LINE_WIDTH_RESET = 16'd320;
  localparam int          QUEUE_DEPTH      = 4;
  localparam int          QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int          TDATA_W          = 40;

  // Decoding phase of the stream parser
  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LIT  = 2'd1,
    PH_REP  = 2'd2
  } phase_t;

  typedef enum logic {
    CMD_LIT = 1'b0,
    CMD_REP = 1'b1
  } cmd_kind_t;

  // One unit of work for the back end
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        last;   // final byte of a literal run
    logic [7:0]  count;  // repeat count, 2..128
  } cmd_t;

  // Status from the back end for checking
  typedef struct packed {
    logic        load_eol;
    logic [15:0] column;
  } back_stat_t;

endpackage

[rtl/core/packbits_scanline_decoder_core.sv]
// An accepted data byte is stored in the command queue and then registered into
// the output word. Throughput: one input byte per cycle; the back end expands a
// repeat run into words of up to four pixels, and input stalls once the
// four-entry command queue fills. Control bytes produce no output.
// Reset (rst, synchronous) clears phase, queue, column and output valid, and
// sets line_width to 320.
`include "assert_macros.svh"

module packbits_scanline_decoder_core (
  input  logic        clk,
  input  logic        rst,
  // Configuration: line_width
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // Compressed stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  // Pixel words out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] lane0, [15:8] lane1, [23:16] lane2,
                                 // [31:24] lane3, [34:32] lane_count, rest zero
  output logic        m_tlast,   // end_of_line
  output logic        m_tuser    // [0] run_overrun
);
  import pbd_pkg::*;

  logic       push, q_full, q_pop, q_valid;
  cmd_t       push_cmd, q_cmd;
  back_stat_t bk_stat;

  assign cfg_ready = 1'b1;

  pbd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  pbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  pbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .stat      (bk_stat)
  );

  // Checks
  `ASSERT_SAME(a_lane_count_range, m_tvalid, (m_tdata[34:32] != 3'd0) && (m_tdata[34:32] <= 3'd4))
  `ASSERT_SAME(a_overrun_on_eol, m_tvalid && m_tuser, m_tlast)
  `ASSERT_SAME(a_unused_lanes_zero, m_tvalid && (m_tdata[34:32] == 3'd1), m_tdata[31:8] == 24'd0)
  `ASSERT_NEXT(a_eol_wraps_column, bk_stat.load_eol, bk_stat.column == 16'd0)

endmodule

[rtl/core/pbd_front.sv]
// Front end: accepts stream bytes, tracks the PackBits phase and issues commands.
// Depends on pbd_pkg.
module pbd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          q_full,
  output logic          push,
  output pbd_pkg::cmd_t push_cmd
);
  import pbd_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] run_left, run_left_next;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Next phase and run length
  always_comb begin
    phase_next    = phase;
    run_left_next = run_left;
    if (accept) begin
      unique case (phase)
        PH_LIT: begin
          run_left_next = run_left - 8'd1;
          if (run_left == 8'd1) phase_next = PH_CTRL;
        end
        PH_REP: begin
          phase_next = PH_CTRL;
        end
        default: begin
          if (in_byte == SKIP_CODE) begin
            phase_next = PH_CTRL;
          end else if (!in_byte[7]) begin
            phase_next    = PH_LIT;
            run_left_next = in_byte + 8'd1;
          end else begin
            phase_next    = PH_REP;
            run_left_next = 8'(9'd257 - {1'b0, in_byte});
          end
        end
      endcase
    end
  end

  // Command issue
  always_comb begin
    push          = 1'b0;
    push_cmd.kind = CMD_LIT;
    push_cmd.data = in_byte;
    push_cmd.last = (run_left == 8'd1);
    push_cmd.count = run_left;
    unique case (phase)
      PH_LIT: begin
        push = accept;
      end
      PH_REP: begin
        push          = accept;
        push_cmd.kind = CMD_REP;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_CTRL;
      run_left <= '0;
    end else begin
      phase    <= phase_next;
      run_left <= run_left_next;
    end
  end

endmodule

[rtl/core/pbd_queue.sv]
// Short command queue between front and back end.
// Depends on pbd_pkg for the command type and depth.
module pbd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pbd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output pbd_pkg::cmd_t head_cmd
);
  import pbd_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_pop;

  assign full       = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  // Store incoming command
  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_cmd;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule

[rtl/core/pbd_back.sv]
// Back end: expands commands into pixel words, tracks column and line end.
// Depends on pbd_pkg; holds the line width register and the output register.
module pbd_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [15:0]             cfg_data,
  input  logic                    q_valid,
  input  pbd_pkg::cmd_t           q_cmd,
  output logic                    pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [pbd_pkg::TDATA_W-1:0] m_tdata,
  output logic                    m_tlast,
  output logic                    m_tuser,
  output pbd_pkg::back_stat_t     stat
);
  import pbd_pkg::*;

  logic [15:0] line_width;
  logic [15:0] column, column_next;
  logic        rep_busy;
  logic [7:0]  rep_left;
  logic        ovr_seen;

  logic        out_free, step, is_lit, emit;
  logic [15:0] room;
  logic [16:0] col_inc;
  logic [7:0]  left;
  logic [2:0]  n_rep, res_n;
  logic        res_eol, res_ovr;
  logic [31:0] lanes;

  assign out_free = !m_tvalid || m_tready;
  assign step     = q_valid && out_free;
  assign is_lit   = (q_cmd.kind == CMD_LIT);
  assign emit     = step && !(is_lit && ovr_seen);
  assign left     = rep_busy ? rep_left : q_cmd.count;

  // Room left on the line, at least one
  always_comb begin
    col_inc = {1'b0, column} + 17'd1;
    room    = (col_inc >= {1'b0, line_width}) ? 16'd1 : (line_width - column);
  end

  // Size and flags of the next word
  always_comb begin
    n_rep = (left > 8'd4) ? 3'd4 : left[2:0];
    if ({13'b0, n_rep} > room) n_rep = room[2:0];
    if (is_lit) begin
      res_n   = 3'd1;
      res_eol = (room == 16'd1);
      res_ovr = res_eol && !q_cmd.last;
    end else begin
      res_n   = n_rep;
      res_eol = ({13'b0, n_rep} == room);
      res_ovr = res_eol && (left != {5'b0, n_rep});
    end
    lanes[7:0]   = q_cmd.data;
    lanes[15:8]  = (res_n > 3'd1) ? q_cmd.data : 8'd0;
    lanes[23:16] = (res_n > 3'd2) ? q_cmd.data : 8'd0;
    lanes[31:24] = (res_n > 3'd3) ? q_cmd.data : 8'd0;
    column_next  = res_eol ? 16'd0 : (column + {13'b0, res_n});
  end

  // Pop a literal each step, a repeat once it is used up or hits line end
  assign pop = step && (is_lit || res_eol || (left == {5'b0, n_rep}));

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
      column     <= '0;
      rep_busy   <= 1'b0;
      rep_left   <= '0;
      ovr_seen   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) line_width <= cfg_data;
      if (emit) column <= column_next;
      if (step && !is_lit) begin
        rep_busy <= !pop;
        rep_left <= left - {5'b0, n_rep};
      end
      if (step && is_lit) begin
        if (q_cmd.last) ovr_seen <= 1'b0;
        else if (emit && res_eol) ovr_seen <= 1'b1;
      end
      if (out_free) m_tvalid <= emit;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {5'b0, res_n, lanes};
      m_tlast <= res_eol;
      m_tuser <= res_ovr;
    end
  end

  assign stat.load_eol = emit && res_eol;
  assign stat.column   = column;

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for the PackBits scanline decoder core.
// Depends on pbd_pkg and packbits_scanline_decoder_core; drives the stream and
// config ports, predicts every pixel word, and checks each word as it leaves.
`timescale 1ns / 1ps

module testbench;
  import pbd_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_LEN   = 7;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 16;
  localparam int PHASE_ITEMS = 40;
  localparam int PRINT_CAP   = 40;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN   = 2'd0,
    RX_COIN   = 2'd1,
    RX_SPARSE = 2'd2,
    RX_BURSTY = 2'd3
  } rx_mode_t;

  // Predicts pixel words from accepted stream bytes and checks the output
  class pixel_scoreboard;
    typedef struct packed {
      logic [7:0] lane0;
      logic [7:0] lane1;
      logic [7:0] lane2;
      logic [7:0] lane3;
      logic [2:0] count;
      logic       eol;
      logic       ovr;
    } pixel_word_t;

    phase_t        phase;
    logic [7:0]    run_left;
    logic [15:0]   column;
    logic          tail_drop;
    logic [15:0]   width;
    pixel_word_t   word_q[$];
    int            fails;

    function new();
      phase     = PH_CTRL;
      run_left  = 8'd0;
      column    = 16'd0;
      tail_drop = 1'b0;
      width     = LINE_WIDTH_RESET;
      fails     = 0;
    endfunction

    function void set_width(logic [15:0] w);
      width = w;
    endfunction

    function int pending();
      return word_q.size();
    endfunction

    // Pixels that still fit on this line; at least one so a pixel always lands
    function int unsigned room_on_line();
      int unsigned c;
      int unsigned w;
      c = column;
      w = width;
      return (c + 1 >= w) ? 1 : (w - c);
    endfunction

    function void add_word(logic [7:0] b, int unsigned n, logic eol, logic ovr);
      pixel_word_t pw;
      pw.lane0 = b;
      pw.lane1 = (n > 1) ? b : 8'd0;
      pw.lane2 = (n > 2) ? b : 8'd0;
      pw.lane3 = (n > 3) ? b : 8'd0;
      pw.count = n[2:0];
      pw.eol   = eol;
      pw.ovr   = ovr;
      word_q.push_back(pw);
    endfunction

    // Advance the decoder state by one accepted byte
    function void note_byte(logic [7:0] b);
      int unsigned r;
      int unsigned left;
      int unsigned n;
      logic        eol;
      logic        ovr;
      case (phase)
        PH_LIT: begin
          r = room_on_line();
          if (run_left > 0) run_left = run_left - 8'd1;
          if (!tail_drop) begin
            eol = (r == 1);
            ovr = eol && (run_left > 0);
            add_word(b, 1, eol, ovr);
            if (eol) begin
              column = 16'd0;
              if (ovr) tail_drop = 1'b1;
            end else begin
              column = column + 16'd1;
            end
          end
          if (run_left == 0) begin
            phase     = PH_CTRL;
            tail_drop = 1'b0;
          end
        end
        PH_REP: begin
          left = run_left;
          while (left > 0) begin
            r = room_on_line();
            n = (left < 4) ? left : 4;
            if (n > r) n = r;
            left = left - n;
            if (n == r) begin
              // split at the line end and drop whatever is left of the run
              add_word(b, n, 1'b1, left > 0);
              column = 16'd0;
              left   = 0;
            end else begin
              add_word(b, n, 1'b0, 1'b0);
              column = column + n[15:0];
            end
          end
          run_left  = 8'd0;
          phase     = PH_CTRL;
          tail_drop = 1'b0;
        end
        default: begin
          tail_drop = 1'b0;
          if (b == SKIP_CODE) begin
            phase    = PH_CTRL;
            run_left = 8'd0;
          end else if (b < SKIP_CODE) begin
            phase    = PH_LIT;
            run_left = b + 8'd1;
          end else begin
            phase    = PH_REP;
            run_left = 8'(9'd257 - {1'b0, b});
          end
        end
      endcase
    endfunction

    function void report_mismatch(string what, int got, int want);
      if (fails < PRINT_CAP)
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      fails++;
    endfunction

    // Compare one accepted pixel word with the oldest prediction
    function void check_word(logic [TDATA_W-1:0] data, logic last, logic user);
      pixel_word_t pw;
      if (word_q.size() == 0) begin
        report_mismatch("unexpected word", int'(data[34:0]), 0);
        return;
      end
      pw = word_q.pop_front();
      if (data[7:0] !== pw.lane0)
        report_mismatch("lane0", int'(data[7:0]), int'(pw.lane0));
      if (data[15:8] !== pw.lane1)
        report_mismatch("lane1", int'(data[15:8]), int'(pw.lane1));
      if (data[23:16] !== pw.lane2)
        report_mismatch("lane2", int'(data[23:16]), int'(pw.lane2));
      if (data[31:24] !== pw.lane3)
        report_mismatch("lane3", int'(data[31:24]), int'(pw.lane3));
      if (data[34:32] !== pw.count)
        report_mismatch("lane_count", int'(data[34:32]), int'(pw.count));
      if (data[TDATA_W-1:35] !== '0)
        report_mismatch("tdata pad", int'(data[TDATA_W-1:35]), 0);
      if (last !== pw.eol) report_mismatch("end_of_line", int'(last), int'(pw.eol));
      if (user !== pw.ovr) report_mismatch("run_overrun", int'(user), int'(pw.ovr));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_data = 16'd0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = 8'd0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tlast;
  logic               m_tuser;

  pixel_scoreboard    sb = new();
  logic [7:0]         byte_q[$];
  int                 burst_left = 0;
  int                 cycle_count = 0;
  rx_mode_t           rx_mode = RX_OPEN;
  int                 rx_hold = 0;

  packbits_scanline_decoder_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Count cycles and give up at the limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stall the pixel side on a pattern that changes after a random hold
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_hold <= $urandom_range(20, 200);
    end else begin
      rx_hold <= rx_hold - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= (cycle_count % 16) < 6;
    endcase
  end

  // Check every pixel word taken by the receiver
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast, m_tuser);
  end

  // Send one byte, opening a fresh burst after a random gap when one runs out
  task automatic push_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    burst_left--;
  endtask

  task automatic send_queued();
    while (byte_q.size() > 0) push_byte(byte_q.pop_front());
    s_tvalid   <= 1'b0;
    burst_left = 0;
  endtask

  // Hold the stream until every predicted word is out and the pipe is empty
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_width(logic [15:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_width(w);
  endtask

  // Queue one well-formed run with random content, or a little noise
  task automatic queue_random_run();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 127) : $urandom_range(0, 7);
      byte_q.push_back(8'(len));
      repeat (len + 1) byte_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 128) : $urandom_range(2, 16);
      byte_q.push_back(8'(257 - len));
      byte_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      byte_q.push_back(SKIP_CODE);
    end else begin
      repeat ($urandom_range(1, 3)) byte_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [15:0] widths[$];
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset width: skip code, one- and two-byte literals, both repeat extremes
    byte_q = '{8'h80, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h7E,
               8'hFF, 8'h55, 8'h81, 8'hA5, 8'hFE, 8'h3C};
    send_queued();

    // Narrow the line while the column sits past it, then overrun both run kinds
    write_width(16'd3);
    byte_q = '{8'h04, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'hF9, 8'h66, 8'h80};
    send_queued();

    // Random phases, each at its own width
    widths = '{16'd1, 16'd0, 16'd65535, 16'd2, 16'd4, 16'd5, 16'd7, 16'd11,
               16'($urandom_range(1, 64)), 16'd320};
    foreach (widths[i]) begin
      write_width(widths[i]);
      while (byte_q.size() < PHASE_ITEMS) queue_random_run();
      send_queued();
    end

    drain();
    if (sb.fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
